// ===== hw/rtl/rbt_pkg.sv =====
// ----------------------------------------------------------------------------
// rbt_pkg
// Shared widths, codes and types for the relay burn time throttle.
// ----------------------------------------------------------------------------
package rbt_pkg;

	localparam int CHANNELS  = 6;
	localparam int CHIDX_W   = $clog2(CHANNELS);
	localparam int CH_W      = 3;
	localparam int HEAT_W    = 20;
	localparam int ELAPSED_W = 16;
	localparam int RATE_W    = 16;
	localparam int MASK_W    = 6;
	localparam int FRAC_W    = 8;
	localparam int LOSS_W    = ELAPSED_W + RATE_W - FRAC_W;
	localparam int CFG_W     = 20;

	localparam logic [HEAT_W-1:0] HEAT_MAX   = {HEAT_W{1'b1}};
	localparam logic [HEAT_W-1:0] RST_MAX_BURN = HEAT_W'(2048);
	localparam logic [RATE_W-1:0] RST_COOLING  = RATE_W'(256);
	localparam logic [HEAT_W-1:0] RST_LOCKOUT  = HEAT_W'(1024);
	localparam logic [MASK_W-1:0] RST_MASK     = MASK_W'(27);

	typedef enum logic [1:0] {
		CFG_MAX_BURN      = 2'd0,
		CFG_COOLING_RATE  = 2'd1,
		CFG_LOCKOUT_EXTRA = 2'd2,
		CFG_THROTTLE_MASK = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	// tick broadcast to every channel
	typedef struct packed {
		logic                 tick;
		logic [ELAPSED_W-1:0] elapsed;
		logic [LOSS_W-1:0]    loss;
		logic [HEAT_W-1:0]    max_burn;
		logic [HEAT_W:0]      lock_sum;
	} rbt_tick_t;

	// relay level write to one channel
	typedef struct packed {
		logic write;
		logic level;
	} rbt_req_t;

endpackage

// ===== hw/rtl/rbt_chan.sv =====
// ----------------------------------------------------------------------------
// rbt_chan
// One relay channel: heat accumulator and relay level, warmed or cooled on tick.
// ----------------------------------------------------------------------------
module rbt_chan import rbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rbt_tick_t         upd,
	input  rbt_req_t          req,
	output logic [HEAT_W-1:0] heat
);

	logic [HEAT_W-1:0] heat_q;
	logic              relay_q;
	logic [HEAT_W:0]   warm;
	logic [HEAT_W:0]   warm_lk;
	logic [HEAT_W-1:0] warm_sat;
	logic [HEAT_W-1:0] cool;
	logic [HEAT_W-1:0] heat_d;

	always_comb begin
		warm = {1'b0, heat_q} + {{(HEAT_W + 1 - ELAPSED_W){1'b0}}, upd.elapsed};
		// raise to the lockout level once the limit is reached
		if (warm >= {1'b0, upd.max_burn} && upd.lock_sum > warm) begin
			warm_lk = upd.lock_sum;
		end else begin
			warm_lk = warm;
		end
		warm_sat = warm_lk[HEAT_W] ? HEAT_MAX : warm_lk[HEAT_W-1:0];
		if (upd.loss >= {{(LOSS_W - HEAT_W){1'b0}}, heat_q}) begin
			cool = '0;
		end else begin
			cool = heat_q - upd.loss[HEAT_W-1:0];
		end
		heat_d = relay_q ? warm_sat : cool;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_q  <= '0;
			relay_q <= 1'b0;
		end else begin
			if (upd.tick) begin
				heat_q <= heat_d;
			end
			if (req.write) begin
				relay_q <= req.level;
			end
		end
	end

	assign heat = heat_q;

endmodule

// ===== hw/rtl/relay_burn_time_throttle_top.sv =====
// A request result is held in the input register, then in the result register.
// Throughput: one item per cycle; the input register holds an item only while
// a request result waits for the output register to be taken.
// Ticks give no result and update all channels side by side.
// Reset (arst_n low): all heat to zero, all relays off, config registers to defaults.
// ----------------------------------------------------------------------------
// relay_burn_time_throttle_top
// Per-channel relay heat limiter with stream input, stream result and
// a register write channel.
// ----------------------------------------------------------------------------
module relay_burn_time_throttle_top import rbt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,  // channel[2:0], turn_on[3], elapsed[19:4], zero pad
	input  logic [0:0]       s_tuser,  // operation[0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,  // relay_channel[2:0], relay_level[3], denied[4], zero pad
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [HEAT_W-1:0] max_burn_q;
	logic [RATE_W-1:0] cooling_q;
	logic [HEAT_W-1:0] lockout_q;
	logic [MASK_W-1:0] mask_q;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [CH_W-1:0]      ch_s1;
	logic                 on_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic [LOSS_W-1:0]    loss_s1;

	logic            m_valid_q;
	logic [CH_W-1:0] m_ch_q;
	logic            m_level_q;
	logic            m_denied_q;

	logic                  in_accept;
	logic                  needs_out;
	logic                  out_free;
	logic                  adv;
	logic                  in_range;
	logic                  throttled;
	logic                  deny;
	logic                  grant;
	logic [RATE_W+ELAPSED_W-1:0] product;
	logic [CHIDX_W-1:0]    ch_idx;
	rbt_tick_t             upd;
	rbt_req_t              req   [CHANNELS];
	logic [HEAT_W-1:0]     heat  [CHANNELS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_burn_q <= RST_MAX_BURN;
			cooling_q  <= RST_COOLING;
			lockout_q  <= RST_LOCKOUT;
			mask_q     <= RST_MASK;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_BURN:      max_burn_q <= cfg_data[HEAT_W-1:0];
				CFG_COOLING_RATE:  cooling_q  <= cfg_data[RATE_W-1:0];
				CFG_LOCKOUT_EXTRA: lockout_q  <= cfg_data[HEAT_W-1:0];
				CFG_THROTTLE_MASK: mask_q     <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// --- request stage control
	assign in_range  = {{(32 - CH_W){1'b0}}, ch_s1} < 32'(CHANNELS);
	assign needs_out = valid_s1 && (op_s1 == OP_REQUEST) && in_range;
	assign out_free  = !m_valid_q || m_tready;
	assign adv       = valid_s1 && (!needs_out || out_free);
	assign s_tready  = !valid_s1 || adv;
	assign in_accept = s_tvalid && s_tready;

	// cooling loss is common to all channels: take it once on the way in
	assign product = s_tdata[19:4] * cooling_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1      <= op_t'(s_tuser[0]);
			ch_s1      <= s_tdata[2:0];
			on_s1      <= s_tdata[3];
			elapsed_s1 <= s_tdata[19:4];
			loss_s1    <= product[RATE_W+ELAPSED_W-1:FRAC_W];
		end
	end

	// --- grant decision
	assign ch_idx    = ch_s1[CHIDX_W-1:0];
	assign throttled = ({{(32 - CH_W){1'b0}}, ch_s1} < 32'(MASK_W)) && mask_q[ch_s1];
	assign deny      = on_s1 && throttled && in_range && (heat[ch_idx] >= max_burn_q);
	assign grant     = on_s1 && !deny;

	assign upd.tick     = adv && (op_s1 == OP_TICK);
	assign upd.elapsed  = elapsed_s1;
	assign upd.loss     = loss_s1;
	assign upd.max_burn = max_burn_q;
	assign upd.lock_sum = {1'b0, max_burn_q} + {1'b0, lockout_q};

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		assign req[c].write = adv && needs_out && (ch_idx == CHIDX_W'(c));
		assign req[c].level = grant;

		rbt_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (upd),
			.req    (req[c]),
			.heat   (heat[c])
		);
	end

	// --- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && needs_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && needs_out) begin
			m_ch_q     <= ch_s1;
			m_level_q  <= grant;
			m_denied_q <= deny;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, m_denied_q, m_level_q, m_ch_q};

endmodule

// ===== hw/rtl/rbt_check.sv =====
// ----------------------------------------------------------------------------
// rbt_check
// Port-level checks on the relay burn time throttle, bound to the top level.
// ----------------------------------------------------------------------------
module rbt_check import rbt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a refused request never drives the relay
	a_deny_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[3])
		else $error("denied request left relay on");

	// only channels that exist are reported
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({29'd0, m_tdata[2:0]} < 32'(CHANNELS)))
		else $error("result for a channel out of range");

	// a fresh result comes from an accepted request
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser[0] == OP_REQUEST), 2))
		else $error("result without a request");

endmodule

bind relay_burn_time_throttle_top rbt_check u_rbt_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
